>>> design/awsu_pkg.sv
package awsu_pkg;

  localparam int CountWidthDef = 27;
  localparam int SampleCountW  = 28;
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 28;
  localparam int TableDepth    = 256;
  localparam int MaxResults    = 8;
  localparam int ResW          = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    CMD_TABLE = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_START = 2'd2,
    CMD_NONE  = 2'd3
  } command_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDE_MODE     = 3'd0,
    CFG_DELTA_MODE    = 3'd1,
    CFG_ABSOLUTE_WIDE = 3'd2,
    CFG_START_WIDTH   = 3'd3,
    CFG_SAMPLE_COUNT  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic accept;
    logic decode_en;
    logic finish_en;
  } dp_cmd_t;

  typedef struct packed {
    logic finished;
    logic code_ok;
    logic code_result;
    logic batch_full;
    logic slot_free;
  } dp_sts_t;

  localparam logic [15:0] NarrowCmd [8] = '{
    16'h0001, 16'h0003, 16'h0007, 16'h000F, 16'h001E, 16'h003C, 16'h0078, 16'h00F8
  };
  localparam logic [2:0] NarrowFetch [8] = '{
    3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd1, 3'd0, 3'd0
  };
  localparam logic [15:0] WideCmd [16] = '{
    16'h0001, 16'h0003, 16'h0007, 16'h000F, 16'h001E, 16'h003C, 16'h0078, 16'h00F0,
    16'h01F0, 16'h03F0, 16'h07F0, 16'h0FF0, 16'h1FF0, 16'h3FF0, 16'h7FF0, 16'hFFF0
  };
  localparam logic [2:0] WideFetch [16] = '{
    3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
  };

  localparam logic [15:0] WideEscBase   = 16'hFFF0;
  localparam logic [15:0] NarrowEscBase = 16'h00F8;
  localparam logic [15:0] WideTop       = 16'hFFFF;
  localparam logic [15:0] NarrowTop     = 16'h00FF;
  localparam logic [15:0] SignFlip      = 16'h8000;

  function automatic logic [15:0] code_thresh(input logic wide, input logic [3:0] w);
    code_thresh = wide ? WideCmd[w] : NarrowCmd[w[2:0]];
  endfunction

  function automatic logic [2:0] fetch_len(input logic wide, input logic [3:0] w);
    fetch_len = wide ? WideFetch[w] : NarrowFetch[w[2:0]];
  endfunction

endpackage

>>> design/awsu_ram.sv
module awsu_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/awsu_ctrl.sv
module awsu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        command_i,
  output logic              in_ready_o,
  input  awsu_pkg::dp_sts_t sts_i,
  output awsu_pkg::dp_cmd_t cmd_o
);
  import awsu_pkg::*;

  state_e state_q, state_d;
  logic   step_ok;

  assign step_ok = !sts_i.finished && !sts_i.batch_full && sts_i.code_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && command_i == CMD_BYTE && !sts_i.finished) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!step_ok) begin
          state_d = ST_IDLE;
        end else if (sts_i.code_result) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.slot_free) begin
          state_d = ST_DECODE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_DECODE: cmd_o.decode_en = step_ok;
      ST_FINISH: cmd_o.finish_en = sts_i.slot_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> design/awsu_dp.sv
module awsu_dp #(
  parameter int CountWidth = awsu_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  awsu_pkg::dp_cmd_t             cmd_i,
  output awsu_pkg::dp_sts_t             sts_o,
  input  logic [1:0]                    command_i,
  input  logic [7:0]                    table_index_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          cfg_we_i,
  input  logic [awsu_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [awsu_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [15:0]                   sample_value_o,
  output logic                          has_sample_o,
  output logic                          last_o
);
  import awsu_pkg::*;

  localparam int LimW = (CountWidth + 1 > SampleCountW) ? CountWidth + 1 : SampleCountW;

  // configuration
  logic                    wide_q, delta_q, abs_q;
  logic [3:0]              start_w_q;
  logic [SampleCountW-1:0] count_q;

  // stream state
  logic [31:0]           bit_q, bit_d;
  logic [5:0]            held_q, held_d;
  logic [3:0]            cw_q, cw_d;
  logic [15:0]           prev_q, prev_d;
  logic [CountWidth-1:0] done_q, done_d;
  logic                  finished_q, finished_d;
  logic [ResW-1:0]       n_q, n_d;
  logic                  out_valid_q, out_valid_d;

  // decoded code, held for the finish step
  logic [15:0] val_q;
  logic        stop_q;
  logic [15:0] sample_value_q;
  logic        has_sample_q, last_q;

  // decode
  logic [3:0]  w;
  logic [4:0]  len1;
  logic [16:0] dmask;
  logic [15:0] d, thresh, diff, value;
  logic [2:0]  fetch, esc_len;
  logic [4:0]  fmask;
  logic [31:0] sh1, sh2;
  logic [3:0]  fbits, e;
  logic [7:0]  nw;
  logic [5:0]  pos2, consumed;
  logic        ge, nw_eq, top, stop_bit, wchange, stop;

  // sample
  logic [7:0]      tbl_data;
  logic [15:0]     wide_s, base, sum, sample;
  logic [LimW-1:0] inc_ext, cap, count_ext, limit;
  logic            hit_last, slot_free;

  always_comb begin
    w        = wide_q ? cw_q : {1'b0, cw_q[2:0]};
    len1     = {1'b0, w} + 5'd1;
    dmask    = (17'd1 << len1) - 17'd1;
    d        = bit_q[15:0] & dmask[15:0];
    thresh   = code_thresh(wide_q, w);
    fetch    = fetch_len(wide_q, w);
    ge       = d >= thresh;
    diff     = d - thresh;
    sh1      = bit_q >> len1;
    fmask    = (5'd1 << fetch) - 5'd1;
    fbits    = sh1[3:0] & fmask[3:0];
    nw       = ({4'b0, diff[3:0]} << fetch) + {4'b0, fbits};
    nw_eq    = nw == {4'b0, w};
    pos2     = {1'b0, len1} + {3'b0, fetch};
    sh2      = bit_q >> pos2;
    esc_len  = wide_q ? 3'd4 : 3'd3;
    e        = wide_q ? sh2[3:0] : {1'b0, sh2[2:0]};
    top      = wide_q ? (e == 4'hF) : (e == 4'h7);
    stop_bit = wide_q ? sh2[4] : sh2[3];
    wchange  = ge && !nw_eq;
    stop     = ge && nw_eq && top && stop_bit;
    if (!ge) begin
      consumed = {1'b0, len1};
      value    = d;
    end else if (wchange) begin
      consumed = pos2;
      value    = d;
    end else begin
      consumed = pos2 + {3'b0, esc_len} + {5'b0, top};
      if (top) begin
        value = wide_q ? WideTop : NarrowTop;
      end else begin
        value = (wide_q ? WideEscBase : NarrowEscBase) + {12'b0, e};
      end
    end
  end

  awsu_ram #(
    .Width(8),
    .Depth(TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && command_i == CMD_TABLE),
    .waddr_i (table_index_i),
    .wdata_i (data_byte_i),
    .re_i    (cmd_i.decode_en),
    .raddr_i (value[7:0]),
    .rdata_o (tbl_data)
  );

  always_comb begin
    wide_s    = {val_q[0], val_q[15:1] ^ {15{val_q[0]}}};
    base      = wide_q ? wide_s : {8'b0, tbl_data};
    sum       = base + prev_q;
    if (delta_q) begin
      sample = sum;
    end else if (wide_q && !abs_q) begin
      sample = base ^ SignFlip;
    end else begin
      sample = base;
    end
    if (!wide_q) begin
      sample = {8'b0, sample[7:0]};
    end
    inc_ext   = LimW'(done_q) + LimW'(1);
    cap       = LimW'(1) << CountWidth;
    count_ext = LimW'(count_q);
    limit     = (count_ext > cap) ? cap : count_ext;
    hit_last  = inc_ext >= limit;
  end

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    bit_d       = bit_q;
    held_d      = held_q;
    cw_d        = cw_q;
    prev_d      = prev_q;
    done_d      = done_q;
    finished_d  = finished_q;
    n_d         = n_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.accept) begin
      n_d = '0;
      if (command_i == CMD_START) begin
        bit_d      = '0;
        held_d     = '0;
        cw_d       = wide_q ? start_w_q : {1'b0, start_w_q[2:0]};
        prev_d     = '0;
        done_d     = '0;
        finished_d = count_q == '0;
      end else if (command_i == CMD_BYTE && !finished_q && held_q <= 6'd24) begin
        bit_d  = bit_q | (32'(data_byte_i) << held_q);
        held_d = held_q + 6'd8;
      end
    end else if (cmd_i.decode_en) begin
      bit_d  = bit_q >> consumed;
      held_d = held_q - consumed;
      if (wchange) begin
        cw_d = wide_q ? nw[3:0] : {1'b0, nw[2:0]};
      end
    end else if (cmd_i.finish_en) begin
      n_d         = n_q + ResW'(1);
      out_valid_d = 1'b1;
      if (stop_q) begin
        finished_d = 1'b1;
      end else begin
        done_d = inc_ext[CountWidth-1:0];
        if (delta_q) begin
          prev_d = sum;
        end
        if (hit_last) begin
          finished_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q      <= 1'b0;
      delta_q     <= 1'b0;
      abs_q       <= 1'b0;
      start_w_q   <= '0;
      count_q     <= '0;
      bit_q       <= '0;
      held_q      <= '0;
      cw_q        <= '0;
      prev_q      <= '0;
      done_q      <= '0;
      finished_q  <= 1'b1;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bit_q       <= bit_d;
      held_q      <= held_d;
      cw_q        <= cw_d;
      prev_q      <= prev_d;
      done_q      <= done_d;
      finished_q  <= finished_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_WIDE_MODE:     wide_q    <= cfg_data_i[0];
          CFG_DELTA_MODE:    delta_q   <= cfg_data_i[0];
          CFG_ABSOLUTE_WIDE: abs_q     <= cfg_data_i[0];
          CFG_START_WIDTH:   start_w_q <= cfg_data_i[3:0];
          CFG_SAMPLE_COUNT:  count_q   <= cfg_data_i[SampleCountW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decode_en) begin
      val_q  <= value;
      stop_q <= stop;
    end
    if (cmd_i.finish_en) begin
      sample_value_q <= stop_q ? 16'h0000 : sample;
      has_sample_q   <= !stop_q;
      last_q         <= stop_q || hit_last;
    end
  end

  assign sts_o.finished    = finished_q;
  assign sts_o.code_ok     = held_q >= consumed;
  assign sts_o.code_result = !wchange;
  assign sts_o.batch_full  = n_q == ResW'(MaxResults);
  assign sts_o.slot_free   = slot_free;

  assign out_valid_o    = out_valid_q;
  assign sample_value_o = sample_value_q;
  assign has_sample_o   = has_sample_q;
  assign last_o         = last_q;

endmodule

>>> design/adaptive_width_sample_unpacker.sv
// Adaptive-width sample unpacker. Input words carry a command: a table write loads one
// entry of the 256-entry 8-bit translation table, a start loads the code width from
// start_width and arms a new stream of sample_count samples, and a packed byte is appended
// LSB first to a 32-bit bit store (dropped if more than 24 bits are already held) and then
// decoded. Each byte yields up to eight result words; width-change codes give none, and
// bits of an incomplete code wait for the next byte. A result word carries a 16-bit sample
// (8-bit mode: low byte), or the stop report with has_sample low; last marks the final
// word of the stream, after which bytes are ignored until the next start. A packed byte is
// decoded one code at a time by the single shared code decoder, followed by the registered
// table read; a full output register stalls the block until out_ready_i takes its word.
// The next input word is accepted while the last result word still waits at the output.
// The user must write configuration registers only while the block is idle; the block
// itself does not enforce this.
module adaptive_width_sample_unpacker #(
  parameter int CountWidth = awsu_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    command_i,
  input  logic [7:0]                    table_index_i,
  input  logic [7:0]                    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [15:0]                   sample_value_o,
  output logic                          has_sample_o,
  output logic                          last_o,
  input  logic                          cfg_we_i,
  input  logic [awsu_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [awsu_pkg::CfgDataW-1:0] cfg_data_i
);
  import awsu_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  awsu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .in_ready_o (in_ready_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  awsu_dp #(
    .CountWidth(CountWidth)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .sts_o          (dp_sts),
    .command_i      (command_i),
    .table_index_i  (table_index_i),
    .data_byte_i    (data_byte_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .sample_value_o (sample_value_o),
    .has_sample_o   (has_sample_o),
    .last_o         (last_o)
  );

  a_decode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.decode_en |-> (dp_sts.code_ok && !dp_sts.finished && !dp_sts.batch_full))
    else $error("decode step without a complete code");

  a_finish_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.finish_en |-> dp_sts.slot_free)
    else $error("result written over a pending word");

  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.finish_en |=> out_valid_o)
    else $error("result word not presented");

  a_finished_ignores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && command_i == CMD_BYTE && dp_sts.finished)
    |=> !dp_cmd.decode_en)
    else $error("byte decoded after stream end");

endmodule

>>> verif/adaptive_width_sample_unpacker_checker.sv
`timescale 1ns / 1ps
module adaptive_width_sample_unpacker_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [1:0]                    command_i,
  input  logic [7:0]                    table_index_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [15:0]                   sample_value_i,
  input  logic                          has_sample_i,
  input  logic                          last_i,
  input  logic                          cfg_we_i,
  input  logic [awsu_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [awsu_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            mismatch_count_o,
  output int                            pending_o,
  output logic                          stream_live_o
);
  import awsu_pkg::*;

  localparam logic [27:0] CountCap = 28'h8000000;
  localparam logic [31:0] WideEscape = 32'hFFF0;
  localparam logic [31:0] NarrowEscape = 32'hF8;
  localparam logic [31:0] WideHigh = 32'hFFFF;
  localparam logic [31:0] NarrowHigh = 32'hFF;
  localparam logic [31:0] SignBit = 32'h8000;

  typedef struct packed {
    logic [15:0] value;
    logic        has_sample;
    logic        last;
  } sample_word_t;

  sample_word_t sample_q[$];

  bit          wide_cfg, delta_cfg, abs_cfg;
  logic [3:0]  start_width_cfg;
  logic [27:0] count_cfg;

  logic [31:0] store;
  int          held;
  logic [3:0]  width_code;
  logic [15:0] prev_sample;
  logic [27:0] done_count;
  bit          stream_done;
  logic [7:0]  xlate [256];

  logic [31:0] scan_buf;
  int          scan_held;
  bit          scan_ok;
  int          errors = 0;

  function automatic int code_limit(input bit wide, input int w);
    case (w)
      0: return 32'h01;
      1: return 32'h03;
      2: return 32'h07;
      3: return 32'h0F;
      4: return 32'h1E;
      5: return 32'h3C;
      6: return 32'h78;
      // wide: top w-3 bits of the code set
      default: return wide ? ((32'd1 << (w + 1)) - 32'd16) : 32'hF8;
    endcase
  endfunction

  function automatic int extra_bits(input bit wide, input int w);
    int base;
    base = wide ? 4 : 3;
    if (w < 4) return base;
    if (w - 4 >= base) return 0;
    return base - 1 - (w - 4);
  endfunction

  function automatic logic [31:0] pull_bits(input int n);
    logic [31:0] d;
    if (n == 0 || !scan_ok) return 32'd0;
    if (scan_held < n) begin
      scan_ok = 1'b0;
      return 32'd0;
    end
    d = scan_buf & ((32'd1 << n) - 32'd1);
    scan_buf = scan_buf >> n;
    scan_held -= n;
    return d;
  endfunction

  task automatic unpack_byte(input logic [7:0] b);
    int           produced;
    bit           wide;
    int           w, lim, fetch, esc;
    logic [31:0]  d, nw, e, value, s, top;
    bit           has_value, stop;
    logic [27:0]  cap;
    sample_word_t word;
    if (held <= 24) begin
      store = store | ({24'd0, b} << held);
      held += 8;
    end
    produced = 0;
    while (!stream_done && produced < 8) begin
      wide = wide_cfg;
      w = wide ? int'(width_code) : int'(width_code[2:0]);
      lim = code_limit(wide, w);
      scan_buf = store;
      scan_held = held;
      scan_ok = 1'b1;
      has_value = 1'b0;
      stop = 1'b0;
      value = 32'd0;
      d = pull_bits(w + 1);
      if (scan_ok && d >= lim) begin
        fetch = extra_bits(wide, w);
        nw = pull_bits(fetch) + ((d - lim) << fetch);
        if (nw != w) begin
          if (scan_ok) width_code = wide ? nw[3:0] : {1'b0, nw[2:0]};
        end else begin
          esc = wide ? 4 : 3;
          top = (32'd1 << esc) - 32'd1;
          e = pull_bits(esc);
          if (e == top) begin
            if (pull_bits(1) != 0) begin
              stop = 1'b1;
            end else begin
              value = wide ? WideHigh : NarrowHigh;
              has_value = 1'b1;
            end
          end else begin
            value = (wide ? WideEscape : NarrowEscape) + e;
            has_value = 1'b1;
          end
        end
      end else begin
        value = d;
        has_value = 1'b1;
      end
      if (!scan_ok) break;
      store = scan_buf;
      held = scan_held;
      if (stop) begin
        word = '{value: 16'd0, has_sample: 1'b0, last: 1'b1};
        sample_q.push_back(word);
        stream_done = 1'b1;
        break;
      end
      if (has_value) begin
        if (wide) begin
          // odd codes are negative
          s = value[0] ? (32'd0 - ((value + 32'd1) >> 1)) : (value >> 1);
          s = s & 32'hFFFF;
          if (delta_cfg) begin
            s = (s + prev_sample) & 32'hFFFF;
            prev_sample = s[15:0];
          end else if (!abs_cfg) begin
            s = s ^ SignBit;
          end
          word.value = s[15:0];
        end else begin
          s = {24'd0, xlate[value[7:0]]};
          if (delta_cfg) begin
            s = (s + prev_sample) & 32'hFFFF;
            prev_sample = s[15:0];
          end
          word.value = {8'd0, s[7:0]};
        end
        cap = (count_cfg > CountCap) ? CountCap : count_cfg;
        done_count = done_count + 28'd1;
        word.has_sample = 1'b1;
        word.last = (done_count >= cap);
        if (word.last) stream_done = 1'b1;
        done_count[27] = 1'b0;
        sample_q.push_back(word);
        produced++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sample_word_t want;
    bit           bad;
    if (!rst_ni) begin
      wide_cfg = 1'b0;
      delta_cfg = 1'b0;
      abs_cfg = 1'b0;
      start_width_cfg = 4'd0;
      count_cfg = 28'd0;
      store = 32'd0;
      held = 0;
      width_code = 4'd0;
      prev_sample = 16'd0;
      done_count = 28'd0;
      stream_done = 1'b1;
      for (int i = 0; i < TableDepth; i++) xlate[i] = 8'd0;
      sample_q.delete();
      pending_o <= 0;
      mismatch_count_o <= errors;
      stream_live_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_WIDE_MODE:     wide_cfg = cfg_data_i[0];
          CFG_DELTA_MODE:    delta_cfg = cfg_data_i[0];
          CFG_ABSOLUTE_WIDE: abs_cfg = cfg_data_i[0];
          CFG_START_WIDTH:   start_width_cfg = cfg_data_i[3:0];
          CFG_SAMPLE_COUNT:  count_cfg = cfg_data_i[27:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        case (command_e'(command_i))
          CMD_TABLE: xlate[table_index_i] = data_byte_i;
          CMD_START: begin
            store = 32'd0;
            held = 0;
            width_code = wide_cfg ? start_width_cfg : {1'b0, start_width_cfg[2:0]};
            prev_sample = 16'd0;
            done_count = 28'd0;
            stream_done = (count_cfg == 28'd0);
          end
          CMD_BYTE: if (!stream_done) unpack_byte(data_byte_i);
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (sample_q.size() == 0) begin
          errors++;
          $display("%0t unexpected word: expected none, actual value %h has_sample %b last %b",
                   $time, sample_value_i, has_sample_i, last_i);
        end else begin
          want = sample_q.pop_front();
          bad = 1'b0;
          if (sample_value_i !== want.value) begin
            bad = 1'b1;
            $display("%0t sample_value: expected %h, actual %h", $time, want.value,
                     sample_value_i);
          end
          if (has_sample_i !== want.has_sample) begin
            bad = 1'b1;
            $display("%0t has_sample: expected %b, actual %b", $time, want.has_sample,
                     has_sample_i);
          end
          if (last_i !== want.last) begin
            bad = 1'b1;
            $display("%0t last: expected %b, actual %b", $time, want.last, last_i);
          end
          if (bad) errors++;
        end
      end
      pending_o <= sample_q.size();
      mismatch_count_o <= errors;
      stream_live_o <= !stream_done;
    end
  end

endmodule

>>> verif/adaptive_width_sample_unpacker_test.sv
`timescale 1ns / 1ps
module adaptive_width_sample_unpacker_test;
  import awsu_pkg::*;

  localparam int SettleCycles = 40;
  localparam int WatchdogLimit = 20000;
  localparam int HoldOffCycles = 400;
  localparam int RandomItems = 150;
  localparam logic [27:0] CountMax = 28'h8000000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [1:0]          command_i = CMD_NONE;
  logic [7:0]          table_index_i = 8'd0;
  logic [7:0]          data_byte_i = 8'd0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [15:0]         sample_value_o;
  logic                has_sample_o;
  logic                last_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  int   send_gap_pct = 33;
  int   recv_stall_pct = 56;
  int   hold_token = 0;
  int   mismatch_count;
  int   pending;
  logic stream_live;
  int   random_items;

  adaptive_width_sample_unpacker uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .table_index_i  (table_index_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_value_o (sample_value_o),
    .has_sample_o   (has_sample_o),
    .last_o         (last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  adaptive_width_sample_unpacker_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .command_i        (command_i),
    .table_index_i    (table_index_i),
    .data_byte_i      (data_byte_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sample_value_i   (sample_value_o),
    .has_sample_i     (has_sample_o),
    .last_i           (last_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .stream_live_o    (stream_live)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("** adaptive_width_sample_unpacker: FAILED **");
    $finish;
  end

  task automatic send_word(input command_e cmd, input logic [7:0] idx, input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      command_i <= 2'($urandom);
      table_index_i <= 8'($urandom);
      data_byte_i <= 8'($urandom);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    table_index_i <= idx;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(CMD_BYTE, 8'($urandom), b);
  endtask

  // wait for every word, then let any result-less decode run out
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_reg_e r, input logic [27:0] v);
    cfg_we_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= v;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input bit wide, input bit delta, input bit absolute,
                               input logic [3:0] width, input logic [27:0] count);
    put_reg(CFG_WIDE_MODE, 28'(wide));
    put_reg(CFG_DELTA_MODE, 28'(delta));
    put_reg(CFG_ABSOLUTE_WIDE, 28'(absolute));
    put_reg(CFG_START_WIDTH, 28'(width));
    put_reg(CFG_SAMPLE_COUNT, count);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_stream();
    bit          wide, keep_stream;
    logic [3:0]  width;
    logic [27:0] count;
    int          bytes_left;
    int          pick;
    wide = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: width = 4'd0;
      1: width = 4'd15;
      default: width = 4'($urandom);
    endcase
    case ($urandom_range(9))
      0: count = 28'd0;
      1: count = CountMax;
      2: count = 28'($urandom_range(CountMax));
      default: count = 28'($urandom_range(40, 1));
    endcase
    // sometimes switch modes and carry on with the open stream
    keep_stream = stream_live && ($urandom_range(5) == 0);
    load_settings(wide, 1'($urandom_range(1)), 1'($urandom_range(1)), width, count);
    if (!keep_stream) begin
      send_word(CMD_START, 8'($urandom), 8'($urandom));
      random_items++;
    end
    bytes_left = $urandom_range(16, 4);
    while (bytes_left > 0) begin
      pick = $urandom_range(19);
      if (pick < 2) begin
        send_word(CMD_TABLE, 8'($urandom), 8'($urandom));
        random_items++;
      end else if (pick == 2) begin
        send_word(CMD_NONE, 8'($urandom), 8'($urandom));
      end else if (pick == 3) begin
        send_word(CMD_START, 8'($urandom), 8'($urandom));
        random_items++;
      end else begin
        send_byte(8'($urandom));
        bytes_left--;
        // stream_live still shows the state this byte met
        if (stream_live) random_items++;
        else bytes_left = 0;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    load_settings(1'b0, 1'b0, 1'b0, 4'd0, 28'd0);
    for (int i = 0; i < TableDepth; i++) begin
      if (i == 0) send_word(CMD_TABLE, 8'(i), 8'hFF);
      else if (i == TableDepth - 1) send_word(CMD_TABLE, 8'(i), 8'h00);
      else send_word(CMD_TABLE, 8'(i), 8'($urandom));
    end

    // narrow codes: width change, split code, unknown command, stop
    drain();
    load_settings(1'b0, 1'b0, 1'b0, 4'd0, CountMax);
    send_word(CMD_START, 8'hFF, 8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h0F);
    send_word(CMD_NONE, 8'hFF, 8'hFF);
    send_word(CMD_START, 8'h00, 8'h00);
    send_byte(8'hF1);

    // wide stop split across two bytes
    drain();
    load_settings(1'b1, 1'b0, 1'b0, 4'd0, CountMax);
    send_word(CMD_START, 8'h00, 8'h00);
    send_byte(8'hE1);
    send_byte(8'h03);

    // widest codes, absolute values, count reached
    drain();
    load_settings(1'b1, 1'b0, 1'b1, 4'd15, 28'd2);
    send_word(CMD_START, 8'h00, 8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h12);

    // narrow delta with escapes
    drain();
    load_settings(1'b0, 1'b1, 1'b0, 4'd0, 28'd5);
    send_word(CMD_START, 8'h00, 8'h00);
    send_byte(8'h71);
    send_byte(8'h01);
    send_byte(8'h00);

    // zero count, byte ignored
    drain();
    load_settings(1'b0, 1'b0, 1'b0, 4'd7, 28'd0);
    send_word(CMD_START, 8'h00, 8'h00);
    send_byte(8'h55);

    // mode change in the middle of a stream
    drain();
    load_settings(1'b1, 1'b1, 1'b0, 4'd13, CountMax);
    send_word(CMD_START, 8'h00, 8'h00);
    send_byte(8'h34);
    send_byte(8'h12);
    drain();
    load_settings(1'b0, 1'b1, 1'b0, 4'd13, CountMax);
    send_byte(8'h00);
    send_byte(8'hC3);

    // receiver holds off while short codes pile up
    drain();
    random_items = 0;
    load_settings(1'b0, 1'b0, 1'b0, 4'd0, CountMax);
    send_word(CMD_START, 8'($urandom), 8'($urandom));
    hold_token <= hold_token + 1;
    repeat (24) begin
      send_byte(8'($urandom) & 8'h0E);
      random_items++;
    end

    while (random_items < RandomItems) begin
      if (random_items >= 2 * RandomItems / 3) begin
        send_gap_pct = 0;
        recv_stall_pct <= 0;
      end else if (random_items >= RandomItems / 3) begin
        send_gap_pct = 56;
        recv_stall_pct <= 33;
      end
      drain();
      random_stream();
    end
    drain();

    if (mismatch_count == 0 && pending == 0) begin
      $display("** adaptive_width_sample_unpacker: PASSED **");
    end else begin
      $display("** adaptive_width_sample_unpacker: FAILED **");
    end
    $finish;
  end

endmodule
